// File: rtl/ets_pkg.sv
// ets_pkg: shared types, character constants and classification functions
// for the expression token scanner. No dependencies.
package ets_pkg;

    typedef enum logic [1:0] {
        SM_IDLE    = 2'd0,
        SM_SYMBOL  = 2'd1,
        SM_WORD    = 2'd2,
        SM_INTEGER = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_EOF   = 2'd2,
        KIND_ERROR = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        TT_SYMBOL  = 2'd0,
        TT_WORD    = 2'd1,
        TT_INTEGER = 2'd2,
        TT_NONE    = 2'd3
    } token_type_t;

    typedef enum logic [2:0] {
        CC_OTHER  = 3'd0,
        CC_SYMBOL = 3'd1,
        CC_LETTER = 3'd2,
        CC_DIGIT  = 3'd3,
        CC_SPACE  = 3'd4
    } char_class_t;

    localparam logic [0:0] MODE_TEXT = 1'b0;
    localparam logic [0:0] MODE_EOT  = 1'b1;

    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        cls = CC_OTHER;
        if (c == CH_LT || c == CH_GT || c == CH_PLUS || c == CH_MINUS ||
            c == CH_STAR || c == CH_SLASH || c == CH_LPAREN || c == CH_RPAREN ||
            c == CH_EQ || c == CH_COLON || c == CH_BAR || c == CH_SEMI ||
            c == CH_DOT)
            cls = CC_SYMBOL;
        else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_Z))
            cls = CC_LETTER;
        else if (c >= CH_ZERO && c <= CH_NINE)
            cls = CC_DIGIT;
        else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
            cls = CC_SPACE;
        return cls;
    endfunction

    // whether byte c extends a token open in scan mode m
    function automatic logic extends_token(input scan_mode_t m, input logic [7:0] c);
        logic ext;
        case (m)
            SM_SYMBOL:  ext = (c == CH_GT) || (c == CH_COLON);
            SM_WORD:    ext = (char_class(c) == CC_LETTER);
            SM_INTEGER: ext = (char_class(c) == CC_DIGIT);
            default:    ext = 1'b0;
        endcase
        return ext;
    endfunction

    function automatic token_type_t mode_type(input scan_mode_t m);
        token_type_t t;
        case (m)
            SM_SYMBOL:  t = TT_SYMBOL;
            SM_WORD:    t = TT_WORD;
            SM_INTEGER: t = TT_INTEGER;
            default:    t = TT_SYMBOL;
        endcase
        return t;
    endfunction

    function automatic scan_mode_t class_mode(input char_class_t cls);
        scan_mode_t m;
        case (cls)
            CC_SYMBOL: m = SM_SYMBOL;
            CC_LETTER: m = SM_WORD;
            CC_DIGIT:  m = SM_INTEGER;
            default:   m = SM_IDLE;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/ets_if.sv
// ets_if: valid/ready channel interfaces for text input and token results.
// Depends on nothing; widths of the result channel follow its parameters.
interface ets_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_in;

    modport source (output valid, output mode, output byte_in, input ready);
    modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

interface ets_out_if #(
    parameter int COUNT_BITS    = 16,
    parameter int POSITION_BITS = 24
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [1:0]               token_type;
    logic [7:0]               token_byte;
    logic                     first_byte;
    logic [COUNT_BITS-1:0]    token_count;
    logic [POSITION_BITS-1:0] scan_start;
    logic                     last;

    modport source (output valid, output kind, output token_type, output token_byte,
                    output first_byte, output token_count, output scan_start,
                    output last, input ready);
    modport sink   (input valid, input kind, input token_type, input token_byte,
                    input first_byte, input token_count, input scan_start,
                    input last, output ready);
endinterface

// File: rtl/ets_scan.sv
// ets_scan: input register, scanner state and result generation.
// Depends on ets_pkg and ets_in_if; produces up to two results per item.
module ets_scan #(
    parameter int COUNT_BITS    = 16,
    parameter int POSITION_BITS = 24,
    localparam int RES_BITS     = 14 + COUNT_BITS + POSITION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    ets_in_if.sink              text,
    input  logic [1:0]          free_slots,
    output logic [1:0]          push_cnt,
    output logic [RES_BITS-1:0] res0,
    output logic [RES_BITS-1:0] res1
);

    typedef struct packed {
        logic [1:0]               kind;
        logic [1:0]               token_type;
        logic [7:0]               token_byte;
        logic                     first_byte;
        logic [COUNT_BITS-1:0]    token_count;
        logic [POSITION_BITS-1:0] scan_start;
        logic                     last;
    } result_t;

    function automatic result_t make_res(
        input ets_pkg::result_kind_t  kind,
        input ets_pkg::token_type_t   ttype,
        input logic [7:0]             tbyte,
        input logic                   first,
        input logic [COUNT_BITS-1:0]  count,
        input logic [POSITION_BITS-1:0] start
    );
        result_t r;
        r.kind        = kind;
        r.token_type  = ttype;
        r.token_byte  = tbyte;
        r.first_byte  = first;
        r.token_count = count;
        r.scan_start  = start;
        r.last        = 1'b0;
        return r;
    endfunction

    localparam logic [COUNT_BITS-1:0]    CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // input register
    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_byte_reg;

    // scanner state
    ets_pkg::scan_mode_t      scan_mode_reg, scan_mode_next;
    logic                     halted_reg, halted_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [COUNT_BITS-1:0]    seen_reg, seen_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;

    result_t    r0, r1;
    logic [1:0] n_res;
    logic       advance;

    ets_pkg::char_class_t     cls;
    ets_pkg::scan_mode_t      new_mode;
    logic                     closing;
    logic [COUNT_BITS-1:0]    seen_inc;
    logic [POSITION_BITS-1:0] pos_inc;
    result_t                  opener;
    logic                     has_opener;

    assign cls      = ets_pkg::char_class(s1_byte_reg);
    assign new_mode = ets_pkg::class_mode(cls);
    assign seen_inc = (seen_reg == CNT_MAX) ? seen_reg : seen_reg + 1'b1;
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        r0             = '0;
        r1             = '0;
        n_res          = 2'd0;
        scan_mode_next = scan_mode_reg;
        halted_next    = halted_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        closing        = 1'b0;
        opener         = '0;
        has_opener     = 1'b0;

        if (s1_mode_reg == ets_pkg::MODE_EOT)
        begin
            if (!halted_reg)
            begin
                if (scan_mode_reg != ets_pkg::SM_IDLE)
                begin
                    r0 = make_res(ets_pkg::KIND_END, ets_pkg::mode_type(scan_mode_reg),
                                  8'd0, 1'b0, seen_reg, start_reg);
                    r1 = make_res(ets_pkg::KIND_EOF, ets_pkg::TT_SYMBOL,
                                  8'd0, 1'b0, seen_inc, pos_reg);
                    n_res = 2'd2;
                end
                else
                begin
                    r0 = make_res(ets_pkg::KIND_EOF, ets_pkg::TT_SYMBOL,
                                  8'd0, 1'b0, seen_reg, start_reg);
                    n_res = 2'd1;
                end
            end
            scan_mode_next = ets_pkg::SM_IDLE;
            halted_next    = 1'b0;
            pos_next       = '0;
            seen_next      = '0;
            start_next     = '0;
        end
        else if (!halted_reg)
        begin
            pos_next = pos_inc;
            if (ets_pkg::extends_token(scan_mode_reg, s1_byte_reg))
            begin
                r0 = make_res(ets_pkg::KIND_BYTE, ets_pkg::mode_type(scan_mode_reg),
                              s1_byte_reg, 1'b0, seen_reg, start_reg);
                n_res = 2'd1;
            end
            else
            begin
                closing = (scan_mode_reg != ets_pkg::SM_IDLE);
                if (closing)
                begin
                    r0 = make_res(ets_pkg::KIND_END, ets_pkg::mode_type(scan_mode_reg),
                                  8'd0, 1'b0, seen_reg, start_reg);
                    seen_next  = seen_inc;
                    start_next = pos_reg;
                end
                scan_mode_next = new_mode;
                // the byte that stopped a token is scanned afresh
                if (new_mode != ets_pkg::SM_IDLE)
                begin
                    opener = make_res(ets_pkg::KIND_BYTE, ets_pkg::mode_type(new_mode),
                                      s1_byte_reg, 1'b1, seen_next, start_next);
                    has_opener = 1'b1;
                end
                else if (cls != ets_pkg::CC_SPACE)
                begin
                    opener = make_res(ets_pkg::KIND_ERROR, ets_pkg::TT_SYMBOL,
                                      s1_byte_reg, 1'b0, seen_next, pos_reg);
                    has_opener  = 1'b1;
                    halted_next = 1'b1;
                end
                if (closing && has_opener)
                begin
                    r1    = opener;
                    n_res = 2'd2;
                end
                else if (closing)
                    n_res = 2'd1;
                else if (has_opener)
                begin
                    r0    = opener;
                    n_res = 2'd1;
                end
            end
        end

        case (n_res)
            2'd1:    r0.last = 1'b1;
            2'd2:    r1.last = 1'b1;
            default: ;
        endcase
    end

    assign advance    = s1_valid_reg && (n_res <= free_slots);
    assign text.ready = !s1_valid_reg || advance;
    assign push_cnt   = advance ? n_res : 2'd0;
    assign res0       = r0;
    assign res1       = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (text.ready)
            s1_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_mode_reg <= text.mode;
            s1_byte_reg <= text.byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= ets_pkg::SM_IDLE;
            halted_reg    <= 1'b0;
            pos_reg       <= '0;
            seen_reg      <= '0;
            start_reg     <= '0;
        end
        else if (advance)
        begin
            scan_mode_reg <= scan_mode_next;
            halted_reg    <= halted_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
        end
    end

endmodule

// File: rtl/ets_result_buf.sv
// ets_result_buf: two-entry result buffer that drives the token channel.
// Depends on ets_pkg conventions and ets_out_if; takes up to two results a cycle.
module ets_result_buf #(
    parameter int COUNT_BITS    = 16,
    parameter int POSITION_BITS = 24,
    localparam int RES_BITS     = 14 + COUNT_BITS + POSITION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  logic [RES_BITS-1:0] res0,
    input  logic [RES_BITS-1:0] res1,
    output logic [1:0]          free_slots,
    ets_out_if.source           tokens
);

    typedef struct packed {
        logic [1:0]               kind;
        logic [1:0]               token_type;
        logic [7:0]               token_byte;
        logic                     first_byte;
        logic [COUNT_BITS-1:0]    token_count;
        logic [POSITION_BITS-1:0] scan_start;
        logic                     last;
    } result_t;

    logic [1:0] cnt_reg, cnt_next;
    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;
    logic       pop;
    logic [1:0] cnt_after;
    result_t    base0;

    assign pop        = tokens.valid && tokens.ready;
    assign cnt_after  = cnt_reg - {1'b0, pop};
    assign free_slots = 2'd2 - cnt_after;
    assign base0      = pop ? q1_reg : q0_reg;

    always_comb
    begin
        q0_next  = base0;
        q1_next  = q1_reg;
        cnt_next = cnt_after + push_cnt;
        case (cnt_after)
            2'd0:
            begin
                q0_next = result_t'(res0);
                q1_next = result_t'(res1);
            end
            2'd1:
            begin
                q1_next = result_t'(res0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign tokens.valid       = (cnt_reg != 2'd0);
    assign tokens.kind        = q0_reg.kind;
    assign tokens.token_type  = q0_reg.token_type;
    assign tokens.token_byte  = q0_reg.token_byte;
    assign tokens.first_byte  = q0_reg.first_byte;
    assign tokens.token_count = q0_reg.token_count;
    assign tokens.scan_start  = q0_reg.scan_start;
    assign tokens.last        = q0_reg.last;

endmodule

// File: rtl/expression_token_scanner_top.sv
// expression_token_scanner_top: splits a byte stream into symbol, word and
// integer tokens. Depends on ets_pkg, ets_if, ets_scan and ets_result_buf.
//
//   channel   dir   handshake      payload
//   text      in    valid/ready    mode, byte_in
//   tokens    out   valid/ready    kind, token_type, token_byte, first_byte,
//                                  token_count, scan_start, last
//
// an item yields zero, one or two results and is taken only when the result
// buffer has room for all; tokens carries a single result per cycle while
// ready is high. results pass the input register, then the result buffer.
// rst_n clears the scanner state and empties both stages at once.
// a stall on tokens fills the two-entry buffer, then holds the input register.
module expression_token_scanner_top #(
    parameter int POSITION_BITS = 24,
    parameter int COUNT_BITS    = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    ets_in_if.sink    text,
    ets_out_if.source tokens
);

    localparam int RES_BITS = 14 + COUNT_BITS + POSITION_BITS;

    logic [1:0]          free_slots;
    logic [1:0]          push_cnt;
    logic [RES_BITS-1:0] res0;
    logic [RES_BITS-1:0] res1;

    ets_scan #(
        .COUNT_BITS    (COUNT_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .free_slots (free_slots),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    ets_result_buf #(
        .COUNT_BITS    (COUNT_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1),
        .free_slots (free_slots),
        .tokens     (tokens)
    );

endmodule
